// ===== hdl/tnbp_pkg.sv =====
package tnbp_pkg;

  localparam int FRAC_BITS = 12;
  localparam int SEG_BITS  = FRAC_BITS - 2;
  localparam int ONE_Q     = 1 << FRAC_BITS;

  typedef enum logic [2:0] {
    FN_FWD   = 3'd0,
    FN_OGRAD = 3'd1,
    FN_HID   = 3'd2,
    FN_UPD   = 3'd3,
    FN_LOAD  = 3'd4,
    FN_SET   = 3'd5
  } func_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_MUL_WA,
    OP_ACC_ADD,
    OP_TANH_SEG,
    OP_TANH_MUL,
    OP_TANH_OUT,
    OP_MUL_SQ,
    OP_DERIV,
    OP_MUL_OG,
    OP_MUL_HB,
    OP_MUL_HS,
    OP_GRAD,
    OP_GRAD_CLR,
    OP_UPD_XG,
    OP_UPD_ET,
    OP_UPD_AD,
    OP_UPD_W,
    OP_LOAD_W,
    OP_SET_OUT,
    OP_LOAD_RES
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FMUL,
    S_ACC,
    S_TSEG,
    S_TMUL,
    S_TOUT,
    S_SQ,
    S_DERIV,
    S_MUL_OG,
    S_MUL_HB,
    S_MUL_HS,
    S_GRAD,
    S_GRAD_CLR,
    S_UXG,
    S_UET,
    S_UAD,
    S_UW,
    S_LOAD,
    S_SETOUT,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [7:0] idx;
  } dp_cmd_t;

  function automatic logic [12:0] tanh_tab(input logic [4:0] k);
    logic [12:0] v;
    case (k)
      5'd0:    v = 13'd0;
      5'd1:    v = 13'd1003;
      5'd2:    v = 13'd1893;
      5'd3:    v = 13'd2602;
      5'd4:    v = 13'd3119;
      5'd5:    v = 13'd3475;
      5'd6:    v = 13'd3707;
      5'd7:    v = 13'd3856;
      5'd8:    v = 13'd3949;
      5'd9:    v = 13'd4006;
      5'd10:   v = 13'd4041;
      5'd11:   v = 13'd4062;
      5'd12:   v = 13'd4076;
      5'd13:   v = 13'd4084;
      5'd14:   v = 13'd4089;
      5'd15:   v = 13'd4091;
      default: v = 13'd4093;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/tnbp_ctrl.sv =====
module tnbp_ctrl #(
  parameter int FAN_IN = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        func_i,
  input  logic [3:0]        slot_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              done_res_o,
  output tnbp_pkg::dp_cmd_t cmd_o
);

  localparam int IDX_W = (FAN_IN > 1) ? $clog2(FAN_IN) : 1;

  tnbp_pkg::ctl_state_e state_q, state_d;
  logic [2:0]       func_q, func_d;
  logic             last_q, last_d;
  logic             done_q, done_d;
  logic             oval_q, oval_d;
  logic             dres_q, dres_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             in_range;

  assign in_range    = 32'(slot_i) < FAN_IN;
  assign in_stall_o  = state_q != tnbp_pkg::S_IDLE;
  assign out_valid_o = oval_q;
  assign done_res_o  = dres_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tnbp_pkg::S_IDLE;
      func_q  <= '0;
      last_q  <= 1'b0;
      done_q  <= 1'b0;
      oval_q  <= 1'b0;
      dres_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      func_q  <= func_d;
      last_q  <= last_d;
      done_q  <= done_d;
      oval_q  <= oval_d;
      dres_q  <= dres_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    last_d     = last_q;
    done_d     = done_q;
    cnt_d      = cnt_q;
    dres_d     = dres_q;
    oval_d     = oval_q && out_stall_i;
    cmd_o.op   = tnbp_pkg::OP_NONE;
    cmd_o.idx  = 8'(cnt_q);
    case (state_q)
      tnbp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          last_d = last_i;
          done_d = 1'b1;
          cnt_d  = '0;
          case (func_i)
            tnbp_pkg::FN_FWD: begin
              done_d = last_i;
              if (in_range) state_d = tnbp_pkg::S_FMUL;
              else if (last_i) state_d = tnbp_pkg::S_TSEG;
              else state_d = tnbp_pkg::S_DONE;
            end
            tnbp_pkg::FN_OGRAD: state_d = tnbp_pkg::S_SQ;
            tnbp_pkg::FN_HID: begin
              done_d  = last_i;
              state_d = tnbp_pkg::S_MUL_HB;
            end
            tnbp_pkg::FN_UPD:  state_d = tnbp_pkg::S_UXG;
            tnbp_pkg::FN_LOAD: state_d = in_range ? tnbp_pkg::S_LOAD : tnbp_pkg::S_DONE;
            tnbp_pkg::FN_SET:  state_d = tnbp_pkg::S_SETOUT;
            default: begin
              done_d  = 1'b0;
              state_d = tnbp_pkg::S_DONE;
            end
          endcase
        end
      end
      tnbp_pkg::S_FMUL: begin
        cmd_o.op = tnbp_pkg::OP_MUL_WA;
        state_d  = tnbp_pkg::S_ACC;
      end
      tnbp_pkg::S_MUL_HB: begin
        cmd_o.op = tnbp_pkg::OP_MUL_HB;
        state_d  = tnbp_pkg::S_ACC;
      end
      tnbp_pkg::S_ACC: begin
        cmd_o.op = tnbp_pkg::OP_ACC_ADD;
        if (!last_q) state_d = tnbp_pkg::S_DONE;
        else if (func_q == tnbp_pkg::FN_FWD) state_d = tnbp_pkg::S_TSEG;
        else state_d = tnbp_pkg::S_SQ;
      end
      tnbp_pkg::S_TSEG: begin
        cmd_o.op = tnbp_pkg::OP_TANH_SEG;
        state_d  = tnbp_pkg::S_TMUL;
      end
      tnbp_pkg::S_TMUL: begin
        cmd_o.op = tnbp_pkg::OP_TANH_MUL;
        state_d  = tnbp_pkg::S_TOUT;
      end
      tnbp_pkg::S_TOUT: begin
        cmd_o.op = tnbp_pkg::OP_TANH_OUT;
        state_d  = tnbp_pkg::S_DONE;
      end
      tnbp_pkg::S_SQ: begin
        cmd_o.op = tnbp_pkg::OP_MUL_SQ;
        state_d  = tnbp_pkg::S_DERIV;
      end
      tnbp_pkg::S_DERIV: begin
        cmd_o.op = tnbp_pkg::OP_DERIV;
        state_d  = (func_q == tnbp_pkg::FN_OGRAD) ? tnbp_pkg::S_MUL_OG : tnbp_pkg::S_MUL_HS;
      end
      tnbp_pkg::S_MUL_OG: begin
        cmd_o.op = tnbp_pkg::OP_MUL_OG;
        state_d  = tnbp_pkg::S_GRAD;
      end
      tnbp_pkg::S_MUL_HS: begin
        cmd_o.op = tnbp_pkg::OP_MUL_HS;
        state_d  = tnbp_pkg::S_GRAD_CLR;
      end
      tnbp_pkg::S_GRAD: begin
        cmd_o.op = tnbp_pkg::OP_GRAD;
        state_d  = tnbp_pkg::S_DONE;
      end
      tnbp_pkg::S_GRAD_CLR: begin
        cmd_o.op = tnbp_pkg::OP_GRAD_CLR;
        state_d  = tnbp_pkg::S_DONE;
      end
      tnbp_pkg::S_UXG: begin
        cmd_o.op = tnbp_pkg::OP_UPD_XG;
        state_d  = tnbp_pkg::S_UET;
      end
      tnbp_pkg::S_UET: begin
        cmd_o.op = tnbp_pkg::OP_UPD_ET;
        state_d  = tnbp_pkg::S_UAD;
      end
      tnbp_pkg::S_UAD: begin
        cmd_o.op = tnbp_pkg::OP_UPD_AD;
        state_d  = tnbp_pkg::S_UW;
      end
      tnbp_pkg::S_UW: begin
        cmd_o.op = tnbp_pkg::OP_UPD_W;
        if (cnt_q == IDX_W'(FAN_IN - 1)) begin
          state_d = tnbp_pkg::S_DONE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = tnbp_pkg::S_UXG;
        end
      end
      tnbp_pkg::S_LOAD: begin
        cmd_o.op = tnbp_pkg::OP_LOAD_W;
        state_d  = tnbp_pkg::S_DONE;
      end
      tnbp_pkg::S_SETOUT: begin
        cmd_o.op = tnbp_pkg::OP_SET_OUT;
        state_d  = tnbp_pkg::S_DONE;
      end
      tnbp_pkg::S_DONE: begin
        if (!oval_q || !out_stall_i) begin
          cmd_o.op = tnbp_pkg::OP_LOAD_RES;
          oval_d   = 1'b1;
          dres_d   = done_q;
          state_d  = tnbp_pkg::S_IDLE;
        end
      end
      default: state_d = tnbp_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hdl/tnbp_dpath.sv =====
module tnbp_dpath #(
  parameter int FAN_IN = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic signed [15:0] value_a_i,
  input  logic signed [15:0] value_b_i,
  input  logic [3:0]         slot_i,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [12:0]        cfg_wdata_i,
  input  tnbp_pkg::dp_cmd_t  cmd_i,
  output logic signed [13:0] out_value_o,
  output logic signed [15:0] grad_value_o
);

  localparam int IDX_W = (FAN_IN > 1) ? $clog2(FAN_IN) : 1;
  localparam int F     = tnbp_pkg::FRAC_BITS;

  logic signed [15:0] w_q [FAN_IN];
  logic signed [15:0] dl_q [FAN_IN];
  logic signed [15:0] x_q [FAN_IN];
  logic signed [39:0] acc_q;
  logic signed [13:0] out_q;
  logic signed [15:0] grad_q;
  logic signed [44:0] prod_q;
  logic signed [13:0] deriv_q;
  logic signed [21:0] tmp_q;
  logic [27:0]        m_q;
  logic               neg_q;
  logic signed [15:0] a_q, b_q;
  logic [3:0]         slot_q;
  logic [12:0]        eta_q, alpha_q;
  logic signed [13:0] res_out_q;
  logic signed [15:0] res_grad_q;

  logic [IDX_W-1:0]   sidx, cidx;
  logic signed [27:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [44:0] mul_p, pshift;
  logic signed [40:0] acc_sum;
  logic signed [39:0] acc_sat;
  logic signed [27:0] s_acc;
  logic signed [15:0] grad_sat;
  logic signed [22:0] dsum;
  logic signed [15:0] dnew;
  logic signed [16:0] wsum;
  logic signed [15:0] wnew;
  logic [12:0]        tab_lo, tab_hi, y;
  logic signed [13:0] tanh_out;
  logic signed [13:0] set_out;

  assign sidx   = IDX_W'(slot_q);
  assign cidx   = cmd_i.idx[IDX_W-1:0];
  assign pshift = prod_q >>> F;
  assign s_acc  = 28'(acc_q >>> F);
  assign tab_lo = tnbp_pkg::tanh_tab({1'b0, m_q[13:10]});
  assign tab_hi = tnbp_pkg::tanh_tab(5'({1'b0, m_q[13:10]}) + 5'd1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      tnbp_pkg::OP_MUL_WA: begin
        mul_a = 28'(w_q[sidx]);
        mul_b = 17'(a_q);
      end
      tnbp_pkg::OP_MUL_HB: begin
        mul_a = 28'(a_q);
        mul_b = 17'(b_q);
      end
      tnbp_pkg::OP_TANH_MUL: begin
        mul_a = $signed({15'd0, tab_hi - tab_lo});
        mul_b = $signed({7'd0, m_q[9:0]});
      end
      tnbp_pkg::OP_MUL_SQ: begin
        mul_a = 28'(out_q);
        mul_b = 17'(out_q);
      end
      tnbp_pkg::OP_MUL_OG: begin
        mul_a = 28'(17'(a_q) - 17'(out_q));
        mul_b = 17'(deriv_q);
      end
      tnbp_pkg::OP_MUL_HS: begin
        mul_a = s_acc;
        mul_b = 17'(deriv_q);
      end
      tnbp_pkg::OP_UPD_XG: begin
        mul_a = 28'(x_q[cidx]);
        mul_b = 17'(grad_q);
      end
      tnbp_pkg::OP_UPD_ET: begin
        mul_a = 28'(pshift);
        mul_b = $signed({4'd0, eta_q});
      end
      tnbp_pkg::OP_UPD_AD: begin
        mul_a = 28'(dl_q[cidx]);
        mul_b = $signed({4'd0, alpha_q});
      end
      default: ;
    endcase
  end

  assign mul_p = 45'(mul_a) * 45'(mul_b);

  always_comb begin
    acc_sum = 41'(acc_q) + 41'(prod_q);
    if (acc_sum > 41'sh07F_FFFF_FFFF) acc_sat = 40'sh7F_FFFF_FFFF;
    else if (acc_sum < -41'sh080_0000_0000) acc_sat = -40'sh80_0000_0000;
    else acc_sat = 40'(acc_sum);

    if (pshift > 45'sd32767) grad_sat = 16'sh7FFF;
    else if (pshift < -45'sd32768) grad_sat = -16'sh8000;
    else grad_sat = 16'(pshift);

    dsum = 23'(tmp_q) + 23'(pshift);
    if (dsum > 23'sd32767) dnew = 16'sh7FFF;
    else if (dsum < -23'sd32768) dnew = -16'sh8000;
    else dnew = 16'(dsum);

    wsum = 17'(w_q[cidx]) + 17'(dnew);
    if (wsum > 17'sd32767) wnew = 16'sh7FFF;
    else if (wsum < -17'sd32768) wnew = -16'sh8000;
    else wnew = 16'(wsum);

    if (|m_q[27:14]) y = tnbp_pkg::tanh_tab(5'd16);
    else y = tab_lo + 13'(prod_q >>> tnbp_pkg::SEG_BITS);
    tanh_out = neg_q ? -$signed({1'b0, y}) : $signed({1'b0, y});

    if (a_q > 16'sd4096) set_out = 14'sd4096;
    else if (a_q < -16'sd4096) set_out = -14'sd4096;
    else set_out = 14'(a_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FAN_IN; i++) begin
        w_q[i]  <= '0;
        dl_q[i] <= '0;
        x_q[i]  <= '0;
      end
      acc_q   <= '0;
      out_q   <= '0;
      grad_q  <= '0;
      eta_q   <= 13'd2048;
      alpha_q <= 13'd410;
    end else begin
      if (cfg_we_i) begin
        if (!cfg_addr_i) eta_q <= cfg_wdata_i;
        else alpha_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        tnbp_pkg::OP_MUL_WA:   x_q[sidx] <= a_q;
        tnbp_pkg::OP_ACC_ADD:  acc_q <= acc_sat;
        tnbp_pkg::OP_TANH_OUT: begin
          out_q <= tanh_out;
          acc_q <= '0;
        end
        tnbp_pkg::OP_GRAD:     grad_q <= grad_sat;
        tnbp_pkg::OP_GRAD_CLR: begin
          grad_q <= grad_sat;
          acc_q  <= '0;
        end
        tnbp_pkg::OP_UPD_W: begin
          dl_q[cidx] <= dnew;
          w_q[cidx]  <= wnew;
        end
        tnbp_pkg::OP_LOAD_W:  w_q[sidx] <= a_q;
        tnbp_pkg::OP_SET_OUT: out_q <= set_out;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (accept_i) begin
      a_q    <= value_a_i;
      b_q    <= value_b_i;
      slot_q <= slot_i;
    end
    if (cmd_i.op == tnbp_pkg::OP_TANH_SEG) begin
      neg_q <= s_acc < 0;
      m_q   <= (s_acc < 0) ? 28'(-s_acc) : 28'(s_acc);
    end
    if (cmd_i.op == tnbp_pkg::OP_DERIV) deriv_q <= 14'(45'sd4096 - pshift);
    if (cmd_i.op == tnbp_pkg::OP_UPD_AD) tmp_q <= 22'(pshift);
    if (cmd_i.op == tnbp_pkg::OP_LOAD_RES) begin
      res_out_q  <= out_q;
      res_grad_q <= grad_q;
    end
  end

  assign out_value_o  = res_out_q;
  assign grad_value_o = res_grad_q;

endmodule

// ===== hdl/tanh_neuron_backprop_unit_top.sv =====
// channel  direction  handshake             payload
// in       input      in_valid_i/in_stall_o  func, value_a, value_b, slot, last
// out      output     out_valid_o/out_stall_i out_value, grad_value, done_res
// cfg      input      cfg_we_i               cfg_addr_i, cfg_wdata_i
// one item at a time; a result is registered and the next item is taken meanwhile
// forward element, output gradient, hidden element, load weight, set output and
// unused codes each end in S_DONE, which loads the result; a slot beyond fan-in
// skips the multiply and accumulate of a forward element and the write of a load
// weight; update walks every input through the shared multiplier before S_DONE
// reset clears all weights, deltas, activations and the accumulator at once
// a stalled output holds the block in its final state until the result is taken
module tanh_neuron_backprop_unit_top #(
  parameter int FAN_IN = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic signed [15:0] value_a_i,
  input  logic signed [15:0] value_b_i,
  input  logic [3:0]         slot_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [13:0] out_value_o,
  output logic signed [15:0] grad_value_o,
  output logic               done_res_o,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [12:0]        cfg_wdata_i
);

  tnbp_pkg::dp_cmd_t cmd;
  logic              accept;

  assign accept = in_valid_i && !in_stall_o;

  tnbp_ctrl #(.FAN_IN(FAN_IN)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .slot_i     (slot_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .done_res_o (done_res_o),
    .cmd_o      (cmd)
  );

  tnbp_dpath #(.FAN_IN(FAN_IN)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .value_a_i   (value_a_i),
    .value_b_i   (value_b_i),
    .slot_i      (slot_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .out_value_o (out_value_o),
    .grad_value_o(grad_value_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o) else $error("block not busy after accept");

  a_out_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_value_o <= 14'sd4096 && out_value_o >= -14'sd4096))
    else $error("output outside unit range");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)) else $error("result without item");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int FAN = 16;
  localparam int WDOG_LIMIT = 4000;
  localparam int SETTLE = 4 * FAN + 12;
  localparam logic REG_ETA = 1'b0;
  localparam logic REG_ALPHA = 1'b1;
  localparam logic [2:0] FN_RSV6 = 3'd6;
  localparam logic [2:0] FN_RSV7 = 3'd7;
  localparam longint ACC_HI = (64'sd1 <<< 39) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< 39);

  typedef struct {
    logic [2:0]         func;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [3:0]         slot;
    logic               last;
  } item_t;

  typedef struct {
    logic signed [13:0] outv;
    logic signed [15:0] grad;
    logic               done;
  } result_t;

  class neuron_scoreboard;
    longint wt[FAN];
    longint dlt[FAN];
    longint act[FAN];
    longint acc, outv, grad, eta, alpha;
    result_t due[$];
    int errors;
    longint tab[17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
                        4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093};

    function new();
      for (int i = 0; i < FAN; i++) begin
        wt[i] = 0;
        dlt[i] = 0;
        act[i] = 0;
      end
      acc = 0;
      outv = 0;
      grad = 0;
      eta = 2048;
      alpha = 410;
      errors = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint sat16(longint v);
      return clamp(v, -32768, 32767);
    endfunction

    function longint tanh_q(longint s);
      longint m, seg, y;
      m = s < 0 ? -s : s;
      seg = m >>> tnbp_pkg::SEG_BITS;
      if (seg >= 16) begin
        y = tab[16];
      end else begin
        y = tab[seg] + (((tab[seg + 1] - tab[seg]) *
            (m & ((1 << tnbp_pkg::SEG_BITS) - 1))) >>> tnbp_pkg::SEG_BITS);
      end
      y = clamp(y, 0, tnbp_pkg::ONE_Q);
      return s < 0 ? -y : y;
    endfunction

    function longint slope();
      return tnbp_pkg::ONE_Q - ((outv * outv) >>> tnbp_pkg::FRAC_BITS);
    endfunction

    function void set_reg(logic idx, longint v);
      if (idx == REG_ETA) eta = v;
      else alpha = v;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_item(item_t it);
      result_t r;
      longint a, t, d;
      a = it.a;
      r.done = 1'b0;
      case (it.func)
        tnbp_pkg::FN_FWD: begin
          if (it.slot < FAN) begin
            act[it.slot] = a;
            acc = clamp(acc + wt[it.slot] * a, ACC_LO, ACC_HI);
          end
          if (it.last) begin
            outv = tanh_q(acc >>> tnbp_pkg::FRAC_BITS);
            acc = 0;
            r.done = 1'b1;
          end
        end
        tnbp_pkg::FN_OGRAD: begin
          grad = sat16(((a - outv) * slope()) >>> tnbp_pkg::FRAC_BITS);
          r.done = 1'b1;
        end
        tnbp_pkg::FN_HID: begin
          acc = clamp(acc + a * longint'(it.b), ACC_LO, ACC_HI);
          if (it.last) begin
            grad = sat16(((acc >>> tnbp_pkg::FRAC_BITS) * slope()) >>> tnbp_pkg::FRAC_BITS);
            acc = 0;
            r.done = 1'b1;
          end
        end
        tnbp_pkg::FN_UPD: begin
          for (int i = 0; i < FAN; i++) begin
            t = (act[i] * grad) >>> tnbp_pkg::FRAC_BITS;
            d = sat16(((eta * t) >>> tnbp_pkg::FRAC_BITS) +
                      ((alpha * dlt[i]) >>> tnbp_pkg::FRAC_BITS));
            dlt[i] = d;
            wt[i] = sat16(wt[i] + d);
          end
          r.done = 1'b1;
        end
        tnbp_pkg::FN_LOAD: begin
          if (it.slot < FAN) wt[it.slot] = a;
          r.done = 1'b1;
        end
        tnbp_pkg::FN_SET: begin
          outv = clamp(a, -tnbp_pkg::ONE_Q, tnbp_pkg::ONE_Q);
          r.done = 1'b1;
        end
        default: ;
      endcase
      r.outv = outv;
      r.grad = grad;
      due.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item out=%0d grad=%0d done=%0d",
                                   got.outv, got.grad, got.done);
        return;
      end
      exp_r = due.pop_front();
      if (got.outv !== exp_r.outv || got.grad !== exp_r.grad || got.done !== exp_r.done) begin
        errors++;
        if (errors <= 10) $display("mismatch out %0d/%0d grad %0d/%0d done %0d/%0d (exp/act)",
                                   exp_r.outv, got.outv, exp_r.grad, got.grad,
                                   exp_r.done, got.done);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, done_res, last, cfg_we, cfg_addr;
  logic [2:0] func;
  logic signed [15:0] value_a, value_b, grad_value;
  logic [3:0] slot;
  logic signed [13:0] out_value;
  logic [12:0] cfg_wdata;

  neuron_scoreboard sb = new();
  int tx_pct, rx_pct, sent, idle_cnt;

  tanh_neuron_backprop_unit_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .value_a_i(value_a), .value_b_i(value_b),
    .slot_i(slot), .last_i(last),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_value_o(out_value), .grad_value_o(grad_value), .done_res_o(done_res),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < rx_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{outv: out_value, grad: grad_value, done: done_res});
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIMIT) begin
          $display("tb_top NOT OK");
          $finish;
        end
      end
    end
  end

  task automatic send(item_t it);
    in_valid <= 1'b1;
    func <= it.func;
    value_a <= it.a;
    value_b <= it.b;
    slot <= it.slot;
    last <= it.last;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    sent++;
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic put(logic [2:0] f, logic signed [15:0] a, logic signed [15:0] b,
                     logic [3:0] s, logic l);
    item_t it;
    it.func = f;
    it.a = a;
    it.b = b;
    it.slot = s;
    it.last = l;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [12:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  function automatic logic signed [15:0] rval();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 8192) - 4096);
  endfunction

  task automatic burst();
    int r, n;
    r = $urandom_range(99);
    if (r < 15) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        put(tnbp_pkg::FN_LOAD, rval(), 16'($urandom), 4'($urandom), 1'($urandom));
    end else if (r < 45) begin
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++)
        put(tnbp_pkg::FN_FWD, rval(), 16'($urandom), 4'($urandom), i == n - 1);
    end else if (r < 58) begin
      put(tnbp_pkg::FN_OGRAD, rval(), 16'($urandom), 4'($urandom), 1'($urandom));
    end else if (r < 70) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        put(tnbp_pkg::FN_HID, rval(), rval(), 4'($urandom), i == n - 1);
    end else if (r < 84) begin
      put(tnbp_pkg::FN_UPD, 16'($urandom), 16'($urandom), 4'($urandom), 1'($urandom));
    end else if (r < 90) begin
      put(tnbp_pkg::FN_SET, rval(), 16'($urandom), 4'($urandom), 1'($urandom));
    end else begin
      put(3'($urandom), 16'($urandom), 16'($urandom), 4'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    func = tnbp_pkg::FN_FWD;
    value_a = '0;
    value_b = '0;
    slot = '0;
    last = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_ETA;
    cfg_wdata = '0;
    sent = 0;
    tx_pct = 12;
    rx_pct = 67;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    put(tnbp_pkg::FN_FWD, 16'sd4096, 16'sd0, 4'd0, 1'b1);
    put(tnbp_pkg::FN_LOAD, 16'sh7fff, 16'sh7fff, 4'd15, 1'b0);
    put(tnbp_pkg::FN_LOAD, 16'sh8000, 16'sh8000, 4'd0, 1'b1);
    put(tnbp_pkg::FN_FWD, 16'sh7fff, 16'sd0, 4'd15, 1'b0);
    put(tnbp_pkg::FN_FWD, 16'sh8000, 16'sd0, 4'd0, 1'b0);
    put(tnbp_pkg::FN_FWD, 16'sh7fff, 16'sd0, 4'd15, 1'b1);
    put(tnbp_pkg::FN_OGRAD, 16'sh8000, 16'sd0, 4'd0, 1'b0);
    put(tnbp_pkg::FN_UPD, 16'sd0, 16'sd0, 4'd0, 1'b0);
    put(tnbp_pkg::FN_SET, 16'sh7fff, 16'sd0, 4'd0, 1'b0);
    put(tnbp_pkg::FN_OGRAD, 16'sh8000, 16'sd0, 4'd0, 1'b0);
    put(tnbp_pkg::FN_SET, 16'sh8000, 16'sd0, 4'd0, 1'b0);
    put(tnbp_pkg::FN_SET, 16'sd0, 16'sd0, 4'd0, 1'b0);
    put(tnbp_pkg::FN_HID, 16'sh7fff, 16'sh7fff, 4'd0, 1'b0);
    put(tnbp_pkg::FN_FWD, 16'sh7fff, 16'sd0, 4'd15, 1'b0);
    put(tnbp_pkg::FN_HID, 16'sh8000, 16'sh8000, 4'd0, 1'b1);
    put(tnbp_pkg::FN_UPD, 16'sh7fff, 16'sh7fff, 4'd15, 1'b1);
    put(FN_RSV6, 16'sh7fff, 16'sh7fff, 4'd15, 1'b1);
    put(FN_RSV7, 16'sh8000, 16'sh8000, 4'd0, 1'b0);
    put(tnbp_pkg::FN_SET, 16'sd2048, 16'sd0, 4'd0, 1'b0);
    put(tnbp_pkg::FN_FWD, 16'sd1000, 16'sd0, 4'd3, 1'b1);
    put(tnbp_pkg::FN_UPD, 16'sd0, 16'sd0, 4'd0, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_ETA, 13'd4096);
          write_reg(REG_ALPHA, 13'd0);
        end
        1: begin
          write_reg(REG_ETA, 13'd0);
          write_reg(REG_ALPHA, 13'd4096);
          tx_pct = 67;
          rx_pct = 12;
        end
        default: begin
          write_reg(REG_ETA, 13'($urandom_range(4096)));
          write_reg(REG_ALPHA, 13'($urandom_range(4096)));
          tx_pct = 0;
          rx_pct = 0;
        end
      endcase
      while (sent < 21 + 543 * (ph + 1)) begin
        burst();
        if ($urandom_range(199) == 0) begin
          drain();
          write_reg(REG_ETA, 13'($urandom_range(4096)));
          write_reg(REG_ALPHA, 13'($urandom_range(4096)));
        end
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
